/* hw/rtl/itar_pkg.sv */
// Package for the integer-to-text converter: field widths, character codes,
// register indexes and the types shared by the divider and the top level.
// No dependencies.
`timescale 1ns / 1ps

package itar_pkg;

    localparam int VALUE_BITS_DEFAULT = 32;
    localparam int VALUE_W            = 32;
    localparam int RADIX_W            = 6;
    localparam int DIGIT_W            = 6;
    localparam int CHAR_W             = 8;
    localparam int PADDR_W            = 3;
    localparam int PDATA_W            = 32;

    // Quotient bits resolved by the divider in one clock cycle.
    localparam int STEPS_PER_CYCLE = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;

    localparam logic [DIGIT_W-1:0] DIGIT_MAX_NUM = 6'd9;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN     = 6'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;

    // Register index, taken from paddr[2].
    localparam logic REG_LETTER_CASE = 1'b0;

    typedef struct packed {
        logic               start;
        logic [RADIX_W-1:0] radix;
    } div_ctrl_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [DIGIT_W-1:0] rem;
    } div_status_t;

    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] digit,
                                                        input logic upper);
        logic [CHAR_W-1:0] base;
        base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
        if (digit > DIGIT_MAX_NUM) begin
            digit_to_char = base + CHAR_W'(digit - DIGIT_TEN);
        end else begin
            digit_to_char = CHAR_ZERO + CHAR_W'(digit);
        end
    endfunction

endpackage

/* hw/rtl/integer_to_text_any_radix.sv */
// Integer-to-text converter, any radix 2..36. Each digit takes one divider pass and is then
// written into the digit store; each character then goes through a buffer read and
// an output load, and a leading '-' has an output load of its own. One item is in work
// at a time: the input stalls until the sequencer is back in idle. Reset clears the
// sequencer, the output valid flag and letter_case (lower case); the digit store is
// not cleared.
`timescale 1ns / 1ps

module integer_to_text_any_radix #(
    parameter int VALUE_BITS = itar_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // Input channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [itar_pkg::VALUE_W-1:0] value,
    input  logic [itar_pkg::RADIX_W-1:0] radix,
    input  logic                         signed_mode,
    // Output channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [itar_pkg::CHAR_W-1:0]  out_char,
    output logic                         last,
    // Configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [itar_pkg::PADDR_W-1:0] paddr,
    input  logic [itar_pkg::PDATA_W-1:0] pwdata,
    output logic [itar_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import itar_pkg::*;

    // The divider works on whole groups of quotient bits, so its width is padded.
    localparam int DIV_W  = ((VALUE_BITS + STEPS_PER_CYCLE - 1) / STEPS_PER_CYCLE)
                            * STEPS_PER_CYCLE;
    localparam int DEPTH  = VALUE_BITS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_SIGN = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_LOAD = 3'd4;

    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [CNT_W-1:0]   cnt_dec;
    logic               neg_reg;
    logic               neg_next;
    logic [RADIX_W-1:0] radix_reg;
    logic               letter_case_reg;

    logic               out_valid_reg;
    logic [CHAR_W-1:0]  out_char_reg;
    logic               last_reg;
    logic               out_load;
    logic [CHAR_W-1:0]  out_char_next;
    logic               last_next;
    logic               out_free;

    logic               in_xfer;
    logic               radix_ok;
    logic [VALUE_BITS-1:0] v_in;
    logic [VALUE_BITS-1:0] mag;
    logic               neg_in;

    div_ctrl_t          div_ctrl;
    div_status_t        div_status;
    logic [DIV_W-1:0]   div_dividend;
    logic [DIV_W-1:0]   div_quot;

    logic               buf_wr_en;
    logic               buf_rd_en;
    logic [DIGIT_W-1:0] buf_rd_data;

    logic               cfg_write;

    // ------------------------------------------------------------------
    // Configuration port. Writes complete in the access phase; pready is tied high.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            letter_case_reg <= 1'b0;
        end
        else if (cfg_write && (paddr[2] == REG_LETTER_CASE))
        begin
            letter_case_reg <= pwdata[0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_LETTER_CASE)
        begin
            prdata[0] = letter_case_reg;
        end
    end

    // ------------------------------------------------------------------
    // Input decode. Only the low VALUE_BITS of the value take part. A minus sign
    // appears only for a signed, negative value in radix 10; the magnitude of the
    // most negative value wraps to 2^(VALUE_BITS-1), which is what negation gives.
    // ------------------------------------------------------------------
    assign in_stall = (state_reg != S_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign radix_ok = radix inside {[RADIX_MIN:RADIX_MAX]};
    assign v_in     = VALUE_BITS'(value);
    assign neg_in   = signed_mode && (radix == RADIX_DEC) && v_in[VALUE_BITS-1];
    assign mag      = neg_in ? (~v_in + VALUE_BITS'(1)) : v_in;

    // The output register frees up when it is empty or its transfer happens now.
    assign out_free = !out_valid_reg || !out_stall;
    assign cnt_dec  = cnt_reg - CNT_W'(1);

    // ------------------------------------------------------------------
    // Sequencer. Each divider pass yields one digit, which goes into the
    // store; the quotient feeds the next pass until it reaches zero. The
    // digits are then read back from the top of the store, most significant first.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        neg_next       = neg_reg;
        div_ctrl.start = 1'b0;
        div_ctrl.radix = radix_reg;
        div_dividend   = div_quot;
        buf_wr_en      = 1'b0;
        buf_rd_en      = 1'b0;
        out_load       = 1'b0;
        out_char_next  = CHAR_MINUS;
        last_next      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                // An item with a radix outside the supported range is taken and dropped.
                if (in_xfer && radix_ok)
                begin
                    div_ctrl.start = 1'b1;
                    div_ctrl.radix = radix;
                    div_dividend   = DIV_W'(mag);
                    neg_next       = neg_in;
                    cnt_next       = '0;
                    state_next     = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_status.done)
                begin
                    buf_wr_en = 1'b1;
                    cnt_next  = cnt_reg + CNT_W'(1);
                    if (div_quot == '0)
                    begin
                        state_next = neg_reg ? S_SIGN : S_READ;
                    end
                    else
                    begin
                        div_ctrl.start = 1'b1;
                    end
                end
            end
            S_SIGN:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                buf_rd_en  = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                out_char_next = digit_to_char(buf_rd_data, letter_case_reg);
                last_next     = (cnt_reg == CNT_W'(1));
                if (out_free)
                begin
                    out_load   = 1'b1;
                    cnt_next   = cnt_dec;
                    state_next = last_next ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            neg_reg   <= neg_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            radix_reg <= radix;
        end
        if (out_load)
        begin
            out_char_reg <= out_char_next;
            last_reg     <= last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last      = last_reg;

    // ------------------------------------------------------------------
    // Shared divider and digit store.
    // ------------------------------------------------------------------
    itar_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (div_dividend),
        .status   (div_status),
        .quotient (div_quot)
    );

    itar_digit_buf #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_buf (
        .clk     (clk),
        .wr_en   (buf_wr_en),
        .wr_addr (cnt_reg[ADDR_W-1:0]),
        .wr_data (div_status.rem),
        .rd_en   (buf_rd_en),
        .rd_addr (cnt_dec[ADDR_W-1:0]),
        .rd_data (buf_rd_data)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("digit count exceeds the store depth");

    a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (cnt_reg != '0))
        else $error("digit read with an empty store");

    a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD && out_free && cnt_reg == CNT_W'(1))
        |=> (state_reg == S_IDLE && out_valid_reg && last_reg))
        else $error("final character did not end the item");

    a_bad_radix_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && !radix_ok) |=> (state_reg == S_IDLE))
        else $error("item with an unsupported radix started a conversion");

endmodule

/* hw/rtl/itar_div.sv */
// Iterative restoring divider by a small radix, several quotient bits a cycle.
// Depends on itar_pkg for the control and status types.
`timescale 1ns / 1ps

module itar_div #(
    parameter int DIV_W = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  itar_pkg::div_ctrl_t ctrl,
    input  logic [DIV_W-1:0]    dividend,
    output itar_pkg::div_status_t status,
    output logic [DIV_W-1:0]    quotient
);
    import itar_pkg::*;

    localparam int CYCLES = DIV_W / STEPS_PER_CYCLE;
    localparam int STEP_W = $clog2(CYCLES + 1);

    logic               busy_reg;
    logic               done_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [DIV_W-1:0]   dvd_reg;
    logic [DIV_W-1:0]   dvd_next;
    logic [DIGIT_W-1:0] rem_reg;
    logic [DIGIT_W-1:0] rem_next;
    logic [RADIX_W-1:0] radix_reg;

    // The dividend shifts out at the top while quotient bits fill in from the bottom.
    always_comb
    begin
        logic [DIGIT_W:0]   trial;
        logic [DIGIT_W-1:0] r;
        logic [DIV_W-1:0]   d;
        r = rem_reg;
        d = dvd_reg;
        for (int k = 0; k < STEPS_PER_CYCLE; k++)
        begin
            trial = {r, d[DIV_W-1]};
            d     = {d[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, radix_reg})
            begin
                r    = DIGIT_W'(trial - {1'b0, radix_reg});
                d[0] = 1'b1;
            end
            else
            begin
                r = trial[DIGIT_W-1:0];
            end
        end
        rem_next = r;
        dvd_next = d;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(CYCLES - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            dvd_reg   <= dividend;
            rem_reg   <= '0;
            radix_reg <= ctrl.radix;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign status.rem  = rem_reg;
    assign quotient    = dvd_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a preceding run");

    a_rem_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < radix_reg))
        else $error("remainder not below radix");

endmodule

/* hw/rtl/itar_digit_buf.sv */
// Digit store: one write port and one registered read port.
// Digits are written least significant first and read back in reverse.
`timescale 1ns / 1ps

module itar_digit_buf #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [ADDR_W-1:0]            wr_addr,
    input  logic [itar_pkg::DIGIT_W-1:0] wr_data,
    input  logic                         rd_en,
    input  logic [ADDR_W-1:0]            rd_addr,
    output logic [itar_pkg::DIGIT_W-1:0] rd_data
);
    import itar_pkg::*;

    logic [DIGIT_W-1:0] mem [DEPTH];
    logic [DIGIT_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* bench/itar_checker.sv */
// Checker for the integer-to-text converter: it follows the register port and both
// channels, works out the characters each accepted number should produce, and compares.
// Depends on itar_pkg for widths, character codes and the register index.
`timescale 1ns / 1ps

module itar_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic [itar_pkg::VALUE_W-1:0] value,
    input  logic [itar_pkg::RADIX_W-1:0] radix,
    input  logic                         signed_mode,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [itar_pkg::CHAR_W-1:0]  out_char,
    input  logic                         last,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [itar_pkg::PADDR_W-1:0] paddr,
    input  logic [itar_pkg::PDATA_W-1:0] pwdata,
    input  logic [itar_pkg::PDATA_W-1:0] prdata,
    input  logic                         pready,
    output int                           mismatches,
    output int                           expected_left
);
    import itar_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              is_last;
    } text_char_t;

    text_char_t expected_text[$];
    logic       upper_letters;

    task automatic report_mismatch(input string what);
        $display("[%0t] ERROR %s", $realtime, what);
        mismatches++;
    endtask

    function automatic logic [CHAR_W-1:0] glyph_of(input logic [DIGIT_W-1:0] digit);
        if (digit >= DIGIT_TEN) begin
            return (upper_letters ? CHAR_UPPER_A : CHAR_LOWER_A) + CHAR_W'(digit - DIGIT_TEN);
        end
        return CHAR_ZERO + CHAR_W'(digit);
    endfunction

    // Appends the expected text of one number, most significant digit first.
    function automatic void queue_number_text(input logic [VALUE_W-1:0] bits,
                                              input logic [RADIX_W-1:0] base,
                                              input logic               as_signed);
        logic [VALUE_W-1:0] magnitude;
        logic [DIGIT_W-1:0] digits [VALUE_W+1];
        logic               negative;
        int                 count;
        if (base < RADIX_MIN || base > RADIX_MAX) begin
            return;
        end
        negative  = as_signed && (base == RADIX_DEC) && bits[VALUE_W-1];
        magnitude = negative ? VALUE_W'(-bits) : bits;
        count     = 0;
        do begin
            digits[count] = DIGIT_W'(magnitude % base);
            count++;
            magnitude = magnitude / base;
        end while (magnitude != 0);
        if (negative) begin
            expected_text.push_back('{code: CHAR_MINUS, is_last: 1'b0});
        end
        for (int i = count - 1; i >= 0; i--) begin
            expected_text.push_back('{code: glyph_of(digits[i]), is_last: (i == 0)});
        end
    endfunction

    initial begin
        mismatches    = 0;
        expected_left = 0;
    end

    always @(posedge clk or negedge rst_n) begin
        text_char_t want;
        if (!rst_n) begin
            upper_letters = 1'b0;
            expected_text.delete();
        end else begin
            if (psel && penable && pready && paddr[2] == REG_LETTER_CASE) begin
                if (pwrite) begin
                    upper_letters = pwdata[0];
                end else if (prdata !== PDATA_W'(upper_letters)) begin
                    report_mismatch($sformatf("letter_case read %h, want %0d",
                                              prdata, upper_letters));
                end
            end
            if (out_valid && !out_stall) begin
                if (expected_text.size() == 0) begin
                    report_mismatch($sformatf("character %h with none expected", out_char));
                end else begin
                    want = expected_text.pop_front();
                    if (out_char !== want.code) begin
                        report_mismatch($sformatf("out_char %h, want %h", out_char, want.code));
                    end
                    if (last !== want.is_last) begin
                        report_mismatch($sformatf("last %b, want %b on %h",
                                                  last, want.is_last, want.code));
                    end
                end
            end
            if (in_valid && !in_stall) begin
                queue_number_text(value, radix, signed_mode);
            end
        end
        expected_left = expected_text.size();
    end

endmodule

/* bench/testbench.sv */
// Top of the integer-to-text converter bench: clock, reset, register writes and
// number stimulus, plus the verdict. Depends on itar_pkg, the converter and
// itar_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module testbench;
    import itar_pkg::*;

    // Cycles with no transfer at all before the run is declared hung. The slowest
    // number (radix 2, 32 digits), the longest receiver stalls and the SETTLE_CYCLES
    // drain before a register write all stay well inside this limit, so it is ample.
    localparam int WATCHDOG_LIMIT = 4000;
    // Cycles allowed for the converter to finish an item that yields no text.
    localparam int SETTLE_CYCLES  = 300;
    localparam int PHASE_ITEMS    = 150;

    localparam logic [PADDR_W-1:0] ADDR_LETTER_CASE = {REG_LETTER_CASE, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_UNMAPPED    = {~REG_LETTER_CASE, 2'b00};

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [VALUE_W-1:0] value;
    logic [RADIX_W-1:0] radix;
    logic               signed_mode;
    logic               out_valid;
    logic               out_stall;
    logic [CHAR_W-1:0]  out_char;
    logic               last;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int   mismatches;
    int   expected_left;
    int   quiet_cycles;
    // While set, neither the sender nor the receiver inserts idle cycles.
    logic full_rate;

    integer_to_text_any_radix u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .radix      (radix),
        .signed_mode(signed_mode),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_char   (out_char),
        .last       (last),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    itar_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .value        (value),
        .radix        (radix),
        .signed_mode  (signed_mode),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_char     (out_char),
        .last         (last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .mismatches   (mismatches),
        .expected_left(expected_left)
    );

    initial begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Idle lengths: mostly none; otherwise a random length, usually from the lower of two ranges.
    function automatic int pick_idle();
        int roll;
        roll = $urandom_range(0, 99);
        if (full_rate || roll < 55) begin
            return 0;
        end
        if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // The receiver stalls on its own schedule, changing only at falling edges, so
    // stalls land on every phase of the converter's work.
    initial begin
        int stall_left;
        out_stall  = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge clk);
            if (full_rate) begin
                stall_left = 0;
                out_stall  = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_stall = 1'b1;
            end else begin
                stall_left = pick_idle();
                out_stall  = (stall_left > 0);
                if (stall_left > 0) begin
                    stall_left--;
                end
            end
        end
    end

    // Hang detection: any transfer on either channel or the register port counts
    // as progress.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (psel && penable && pready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("integer_to_text_any_radix: mismatch");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Register access: setup cycle, then access cycle; pready is always high, so
    // the access completes with no wait states.
    task automatic register_access(input logic is_write, input logic [PADDR_W-1:0] addr,
                                   input logic [PDATA_W-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = is_write;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do begin
            @(posedge clk);
        end while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Stops the sender until every expected character has come out, then gives the
    // converter time to finish an item that produced no text at all.
    task automatic drain_converter();
        in_valid = 1'b0;
        while (expected_left != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Sets the letter case through the register, with junk in the unused upper
    // bits, and reads it back. The checker follows both accesses.
    task automatic set_letter_case(input logic upper);
        drain_converter();
        register_access(1'b1, ADDR_LETTER_CASE,
                        {31'($urandom_range(0, 32'h7FFF_FFFF)), upper});
        register_access(1'b0, ADDR_LETTER_CASE, '0);
    endtask

    // One number transfer. Called at a falling edge; returns at a falling edge with valid
    // still high, so back-to-back calls with no idle gap keep valid up without a dip.
    task automatic send_number(input logic [VALUE_W-1:0] bits, input logic [RADIX_W-1:0] base,
                               input logic as_signed);
        int gap;
        gap = pick_idle();
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        value       = bits;
        radix       = base;
        signed_mode = as_signed;
        in_valid    = 1'b1;
        do begin
            @(posedge clk);
        end while (in_stall);
        @(negedge clk);
    endtask

    function automatic logic [VALUE_W-1:0] random_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4:          return $urandom >> $urandom_range(1, 31);
            5:          return $urandom_range(0, 40);
            6:          return 32'h8000_0000 + $urandom_range(0, 3);
            7:          return 32'hFFFF_FFFF - $urandom_range(0, 3);
            8:          return 32'h7FFF_FFFF - $urandom_range(0, 3);
            default:    return 32'h0000_0001 << $urandom_range(0, 31);
        endcase
    endfunction

    // Mostly legal radices with decimal favored, since only decimal shows a sign;
    // a few out-of-range radices go in as noise and are expected to give no text.
    function automatic logic [RADIX_W-1:0] random_radix();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            return $urandom_range(0, 1) ? RADIX_W'($urandom_range(0, 1))
                                        : RADIX_W'($urandom_range(37, 63));
        end
        if (roll < 34) begin
            return RADIX_DEC;
        end
        return RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
    endfunction

    task automatic random_phase();
        logic [RADIX_W-1:0] base;
        int                 legal;
        legal = 0;
        while (legal < PHASE_ITEMS) begin
            // Stretches of full rate are mixed at random with stretches of random idling.
            if (legal % 32 == 0) begin
                full_rate = ($urandom_range(0, 3) == 0);
            end
            // The sender holds off now and then, and always once mid-phase, until
            // the converter has delivered everything.
            if (legal == PHASE_ITEMS / 2 || $urandom_range(0, 99) == 0) begin
                in_valid = 1'b0;
                while (expected_left != 0) begin
                    @(negedge clk);
                end
            end
            base = random_radix();
            send_number(random_value(), base, 1'($urandom_range(0, 1)));
            if (base >= RADIX_MIN && base <= RADIX_MAX) begin
                legal++;
            end
        end
        full_rate = 1'b0;
    endtask

    initial begin
        in_valid     = 1'b0;
        value        = '0;
        radix        = RADIX_DEC;
        signed_mode  = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        quiet_cycles = 0;
        full_rate    = 1'b0;
        rst_n        = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Lower case first; a write to the unmapped address must leave it alone.
        set_letter_case(1'b0);
        register_access(1'b1, ADDR_UNMAPPED, 32'hFFFF_FFFF);
        register_access(1'b0, ADDR_LETTER_CASE, '0);

        // Directed numbers: zero, the widest and narrowest radices, the sign cases
        // including the most negative value, the signed flag outside decimal, and
        // radices outside the legal range.
        send_number(32'h0000_0000, RADIX_DEC, 1'b0);
        send_number(32'h0000_0000, RADIX_MIN, 1'b1);
        send_number(32'h0000_0001, RADIX_MIN, 1'b0);
        send_number(32'hFFFF_FFFF, RADIX_MIN, 1'b0);
        send_number(32'hFFFF_FFFF, RADIX_MIN, 1'b1);
        send_number(32'hFFFF_FFFF, RADIX_DEC, 1'b0);
        send_number(32'hFFFF_FFFF, RADIX_DEC, 1'b1);
        send_number(32'h8000_0000, RADIX_DEC, 1'b1);
        send_number(32'h7FFF_FFFF, RADIX_DEC, 1'b1);
        send_number(32'hFFFF_FFF6, RADIX_DEC, 1'b1);
        send_number(32'hDEAD_BEEF, 6'd16, 1'b1);
        send_number(32'hFFFF_FFFF, RADIX_MAX, 1'b0);
        send_number(32'h0000_0023, RADIX_MAX, 1'b0);
        send_number(32'h0012_3456, 6'd8, 1'b1);
        send_number(32'h0000_0009, 6'd3, 1'b0);
        send_number(32'h0000_0005, 6'd0, 1'b0);
        send_number(32'h0000_0005, 6'd1, 1'b1);
        send_number(32'h0000_0005, 6'd37, 1'b0);
        send_number(32'h0000_0005, 6'd63, 1'b1);
        send_number(32'h0000_0014, RADIX_DEC, 1'b0);

        // Same letter digits in upper case, then the random phases.
        set_letter_case(1'b1);
        send_number(32'hDEAD_BEEF, 6'd16, 1'b0);
        send_number(32'hFFFF_FFFF, RADIX_MAX, 1'b1);
        send_number(32'h0000_0023, RADIX_MAX, 1'b0);
        random_phase();
        set_letter_case(1'b0);
        random_phase();
        set_letter_case(1'b1);
        random_phase();

        in_valid = 1'b0;
        while (expected_left != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0 && expected_left == 0) begin
            $display("integer_to_text_any_radix: match");
        end else begin
            $display("integer_to_text_any_radix: mismatch");
        end
        $finish;
    end

endmodule

/* integer_to_text_any_radix.f */
hw/rtl/itar_pkg.sv
hw/rtl/itar_div.sv
hw/rtl/itar_digit_buf.sv
hw/rtl/integer_to_text_any_radix.sv
bench/itar_checker.sv
bench/testbench.sv
